### design/lcst_pkg.sv
// Shared constants, codes and types of the load cell smart tare block.
package lcst_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;

   // Extra bits of the running sum over the sample width.
   localparam int SUM_EXTRA = 7;

   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_REQUIRED = 2'd1;
   localparam logic [1:0] CSR_AVERAGE = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT = 2'd3;

   localparam logic [23:0] THRESHOLD_RST = 24'd100;
   localparam logic [5:0] REQUIRED_RST = 6'd5;
   localparam logic [5:0] AVERAGE_RST = 6'd5;
   localparam logic [15:0] TIMEOUT_RST = 16'd15000;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_NOT_READY = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_STABILIZE = 2'd1;
   localparam logic [1:0] PH_AVERAGE = 2'd2;
   localparam logic [1:0] PH_FALLBACK = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } lcst_div_stat_type;

endpackage

### design/lcst_div.sv
// Iterative restoring divider of a signed sum by a small unsigned count.
module lcst_div #(
   parameter int DW = lcst_pkg::SAMPLE_WIDTH_DEF + lcst_pkg::SUM_EXTRA
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [DW-1:0]       dividend,
   input  logic [5:0]                 divisor,
   output logic signed [DW-1:0]       quotient,
   output lcst_pkg::lcst_div_stat_type stat
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    mag_ff, mag_in;
   logic [5:0]       rem_ff, rem_in;
   logic [5:0]       dsr_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [6:0]       trial;
   logic             ge;

   always_comb begin
      trial = {rem_ff, mag_ff[DW-1]};
      ge = (trial >= {1'b0, dsr_ff});
      rem_in = ge ? 6'(trial - {1'b0, dsr_ff}) : trial[5:0];
      mag_in = {mag_ff[DW-2:0], ge};
      cnt_in = cnt_ff - CNT_W'(1);
      done_in = (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff <= CNT_W'(DW);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= dividend[DW-1] ? DW'(-dividend) : dividend;
         neg_ff <= dividend[DW-1];
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (cnt_ff != '0) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
      end
   end

   // Truncation toward zero: divide the magnitude, then restore the sign.
   assign quotient = neg_ff ? DW'(-mag_ff) : mag_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

### design/load_cell_smart_tare.sv
// Top level of the load cell smart tare controller.
// Requests carry one event each: tare start, raw sample, converter not
// ready, or a one millisecond tick. Every request gives exactly one
// response with the tare phase, the tared sample, the stable run, a done
// flag and the offset after the request.
// A request is taken when req_valid is high and req_stall is low, and a
// response is taken when rsp_valid is high and rsp_stall is low.
// For most requests the response stands in the output register in the
// cycle after the request is taken. A request that closes the averaging
// phase with samples in hand runs the shared serial divider for the mean,
// one quotient bit per cycle over SAMPLE_WIDTH+7 bits, and its response
// is registered once the divider signals done.
// While the divider runs, req_stall is high. A waiting response does not
// block the next request unless the receiver stalls; then req_stall is
// high until the response is taken, and the response holds steady.
// Reset clears the offset, counters and phase and loads the default
// configuration; the block takes requests in the first cycle after reset.
// Configuration registers are written through csr_write_enable.
module load_cell_smart_tare #(
   parameter int SAMPLE_WIDTH = lcst_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_operation,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_phase,
   output logic signed [SAMPLE_WIDTH:0]           rsp_tared_value,
   output logic [5:0]                             rsp_stable_run,
   output logic                                   rsp_tare_done,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_current_offset,
   input  logic                                   csr_write_enable,
   input  logic [lcst_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lcst_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int W = SAMPLE_WIDTH;
   localparam int DW = SAMPLE_WIDTH + lcst_pkg::SUM_EXTRA;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DIV = 1'b1;

   logic [23:0] thr_ff;
   logic [5:0]  req_stable_ff;
   logic [5:0]  avg_ff;
   logic [15:0] timeout_ff;

   logic          state_ff, state_in;
   logic [W-1:0]  off_ff, off_in;
   logic [W:0]    prev_ff, prev_in;
   logic [5:0]    stab_ff, stab_in;
   logic [1:0]    ph_ff, ph_in;
   logic [15:0]   el_ff, el_in;
   logic [DW-1:0] sum_ff, sum_in;
   logic [5:0]    att_ff, att_in;
   logic [5:0]    val_ff, val_in;
   logic [W:0]    tared_in;
   logic          done_in;
   logic          div_go;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_phase_ff;
   logic [W:0]    rsp_tared_ff;
   logic [5:0]    rsp_stable_ff;
   logic          rsp_done_ff;
   logic [W-1:0]  rsp_offset_ff;

   logic                        req_take;
   logic                        rsp_take;
   logic signed [DW-1:0]        quotient;
   lcst_pkg::lcst_div_stat_type div_stat;
   logic [W:0]                  new_off;
   logic [W-1:0]                sat_off;

   assign req_stall = (state_ff == S_DIV) || (rsp_valid_ff && rsp_stall);
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= lcst_pkg::THRESHOLD_RST;
         req_stable_ff <= lcst_pkg::REQUIRED_RST;
         avg_ff <= lcst_pkg::AVERAGE_RST;
         timeout_ff <= lcst_pkg::TIMEOUT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            lcst_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata[23:0];
            lcst_pkg::CSR_REQUIRED: req_stable_ff <= csr_wdata[5:0];
            lcst_pkg::CSR_AVERAGE: avg_ff <= csr_wdata[5:0];
            lcst_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata[15:0];
            default: thr_ff <= thr_ff;
         endcase
      end
   end

   always_comb begin
      logic [W+1:0] diff;
      logic [W+1:0] adiff;
      logic         stable;
      logic         timed_out;
      logic         have;
      logic         finish;

      off_in = off_ff;
      prev_in = prev_ff;
      stab_in = stab_ff;
      ph_in = ph_ff;
      el_in = el_ff;
      sum_in = sum_ff;
      att_in = att_ff;
      val_in = val_ff;
      tared_in = '0;
      done_in = 1'b0;
      div_go = 1'b0;
      finish = 1'b0;

      have = (req_operation == lcst_pkg::OP_SAMPLE);
      timed_out = (el_ff > timeout_ff);
      diff = {tared_in[W], tared_in} - {prev_ff[W], prev_ff};
      adiff = diff;
      stable = 1'b0;

      case (req_operation)
         lcst_pkg::OP_START: begin
            stab_in = '0;
            prev_in = '0;
            el_in = '0;
            sum_in = '0;
            att_in = '0;
            val_in = '0;
            ph_in = lcst_pkg::PH_STABILIZE;
            if (req_stable_ff == 6'd0) begin
               ph_in = (avg_ff == 6'd0) ? lcst_pkg::PH_FALLBACK : lcst_pkg::PH_AVERAGE;
            end
         end
         lcst_pkg::OP_TICK: begin
            if (el_ff != 16'hFFFF) begin
               el_in = el_ff + 16'd1;
            end
         end
         default: begin
            if (have) begin
               tared_in = {req_sample[W-1], req_sample} - {off_ff[W-1], off_ff};
            end
            diff = {tared_in[W], tared_in} - {prev_ff[W], prev_ff};
            adiff = diff[W+1] ? (W+2)'(-diff) : diff;
            stable = ({24'd0, adiff} < {{(W+2){1'b0}}, thr_ff});
            case (ph_ff)
               lcst_pkg::PH_STABILIZE: begin
                  if (have) begin
                     if (stable) begin
                        stab_in = (stab_ff != 6'd63) ? stab_ff + 6'd1 : stab_ff;
                     end else begin
                        stab_in = '0;
                     end
                     prev_in = tared_in;
                  end
                  if ((have && (stab_in >= req_stable_ff)) || timed_out) begin
                     sum_in = '0;
                     att_in = '0;
                     val_in = '0;
                     ph_in = (avg_ff == 6'd0) ? lcst_pkg::PH_FALLBACK : lcst_pkg::PH_AVERAGE;
                  end
               end
               lcst_pkg::PH_AVERAGE: begin
                  if (have) begin
                     sum_in = sum_ff + {{lcst_pkg::SUM_EXTRA{req_sample[W-1]}}, req_sample};
                     val_in = val_ff + 6'd1;
                  end
                  att_in = att_ff + 6'd1;
                  finish = (att_in >= avg_ff) || timed_out;
                  if (finish) begin
                     if (val_in != 6'd0) begin
                        div_go = 1'b1;
                        done_in = 1'b1;
                        ph_in = lcst_pkg::PH_IDLE;
                     end else begin
                        ph_in = lcst_pkg::PH_FALLBACK;
                     end
                  end
               end
               lcst_pkg::PH_FALLBACK: begin
                  if (have) begin
                     off_in = req_sample;
                     done_in = 1'b1;
                     ph_in = lcst_pkg::PH_IDLE;
                  end
               end
               default: begin
                  ph_in = ph_ff;
               end
            endcase
         end
      endcase
   end

   lcst_div #(
      .DW(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take && div_go),
      .dividend (sum_in),
      .divisor  (val_in),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // The mean always fits the sample width, so only the low bits take part.
   always_comb begin
      new_off = {off_ff[W-1], off_ff} + quotient[W:0];
      if (new_off[W] != new_off[W-1]) begin
         sat_off = new_off[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         sat_off = new_off[W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take && div_go) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         off_ff <= '0;
         prev_ff <= '0;
         stab_ff <= '0;
         ph_ff <= lcst_pkg::PH_IDLE;
         el_ff <= '0;
         sum_ff <= '0;
         att_ff <= '0;
         val_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_take) begin
            off_ff <= off_in;
            prev_ff <= prev_in;
            stab_ff <= stab_in;
            ph_ff <= ph_in;
            el_ff <= el_in;
            sum_ff <= sum_in;
            att_ff <= att_in;
            val_ff <= val_in;
         end else if (state_ff == S_DIV && div_stat.done) begin
            off_ff <= sat_off;
         end
         if ((req_take && !div_go) || (state_ff == S_DIV && div_stat.done)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_phase_ff <= ph_in;
         rsp_tared_ff <= tared_in;
         rsp_stable_ff <= stab_in;
         rsp_done_ff <= done_in;
         rsp_offset_ff <= off_in;
      end else if (state_ff == S_DIV && div_stat.done) begin
         rsp_offset_ff <= sat_off;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phase = rsp_phase_ff;
   assign rsp_tared_value = rsp_tared_ff;
   assign rsp_stable_run = rsp_stable_ff;
   assign rsp_tare_done = rsp_done_ff;
   assign rsp_current_offset = rsp_offset_ff;

   a_stall_while_dividing: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> req_stall)
      else $error("request taken while the divider runs");

   a_divider_only_when_busy: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_stat.busy && !div_stat.done)
      else $error("divider active outside the divide state");

   a_response_after_divide: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_stat.done) |=> rsp_valid && rsp_tare_done)
      else $error("divide finished without a done response");

   a_done_means_idle_phase: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tare_done) |-> (rsp_phase == lcst_pkg::PH_IDLE))
      else $error("tare done reported outside the idle phase");

endmodule
